@@ rtl/msap_pkg.sv @@
// Shared types, character codes and decode helpers for the method signature
// argument parser. No dependencies; imported by msap_step and the top level.
package msap_pkg;

    localparam int MAX_ARGS_DEF   = 4;
    localparam int DEPTH_BITS_DEF = 8;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_F_LOW   = 8'h66; // 'f'
    localparam logic [7:0] CH_D_LOW   = 8'h64; // 'd'
    localparam logic [7:0] CH_D_UP    = 8'h44; // 'D'
    localparam logic [7:0] CH_CARET   = 8'h5E; // '^'
    localparam logic [7:0] CH_LBRACE  = 8'h7B; // '{'
    localparam logic [7:0] CH_RBRACE  = 8'h7D; // '}'
    localparam logic [7:0] CH_LPAREN  = 8'h28; // '('
    localparam logic [7:0] CH_RPAREN  = 8'h29; // ')'
    localparam logic [7:0] CH_LBRACK  = 8'h5B; // '['
    localparam logic [7:0] CH_RBRACK  = 8'h5D; // ']'
    localparam logic [7:0] CH_AT      = 8'h40; // '@'
    localparam logic [7:0] CH_QUEST   = 8'h3F; // '?'
    localparam logic [7:0] CH_MINUS   = 8'h2D; // '-'
    localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
    localparam logic [7:0] CH_NINE    = 8'h39; // '9'
    localparam logic [7:0] CH_Q_R_LOW = 8'h72; // 'r'
    localparam logic [7:0] CH_Q_N_LOW = 8'h6E; // 'n'
    localparam logic [7:0] CH_Q_N_UP  = 8'h4E; // 'N'
    localparam logic [7:0] CH_Q_O_LOW = 8'h6F; // 'o'
    localparam logic [7:0] CH_Q_O_UP  = 8'h4F; // 'O'
    localparam logic [7:0] CH_Q_R_UP  = 8'h52; // 'R'
    localparam logic [7:0] CH_Q_V_UP  = 8'h56; // 'V'

    // Token position: return, receiver, selector, then explicit arguments.
    localparam logic [1:0] POS_RETURN   = 2'd0;
    localparam logic [1:0] POS_RECEIVER = 2'd1;
    localparam logic [1:0] POS_SELECTOR = 2'd2;
    localparam logic [1:0] POS_EXPLICIT = 2'd3;

    typedef enum logic [4:0] {
        PH_RET   = 5'b00001,
        PH_TOK   = 5'b00010,
        PH_PTR   = 5'b00100,
        PH_AGG   = 5'b01000,
        PH_TRAIL = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_BRACE   = 2'd1,
        KIND_PAREN   = 2'd2,
        KIND_BRACKET = 2'd3
    } kind_t;

    typedef struct packed {
        phase_t      phase;
        kind_t       open_kind;
        logic        after_at;
        logic [1:0]  arg_pos;
        logic        halted;
        logic [7:0]  ret_char;
    } ctl_t;

    localparam ctl_t CTL_INIT = '{
        phase:     PH_RET,
        open_kind: KIND_NONE,
        after_at:  1'b0,
        arg_pos:   POS_RETURN,
        halted:    1'b0,
        ret_char:  CH_AT
    };

    function automatic logic is_qual(input logic [7:0] c);
        return (c == CH_Q_R_LOW) || (c == CH_Q_N_LOW) || (c == CH_Q_N_UP) ||
               (c == CH_Q_O_LOW) || (c == CH_Q_O_UP) || (c == CH_Q_R_UP) ||
               (c == CH_Q_V_UP);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_float(input logic [7:0] c);
        return (c == CH_F_LOW) || (c == CH_D_LOW) || (c == CH_D_UP);
    endfunction

    function automatic kind_t opener_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            CH_LBRACE: k = KIND_BRACE;
            CH_LPAREN: k = KIND_PAREN;
            CH_LBRACK: k = KIND_BRACKET;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] kind_open(input kind_t k);
        logic [7:0] c;
        unique case (k)
            KIND_BRACE: c = CH_LBRACE;
            KIND_PAREN: c = CH_LPAREN;
            default:    c = CH_LBRACK;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kind_close(input kind_t k);
        logic [7:0] c;
        unique case (k)
            KIND_BRACE: c = CH_RBRACE;
            KIND_PAREN: c = CH_RPAREN;
            default:    c = CH_RBRACK;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/msap_step.sv @@
// Next-state logic for one signature byte: token start, pointer, aggregate
// skip, trailer skip and argument collection. Depends on msap_pkg.
module msap_step #(
    parameter int MAX_ARGS   = msap_pkg::MAX_ARGS_DEF,
    parameter int DEPTH_BITS = msap_pkg::DEPTH_BITS_DEF,
    parameter int CW         = $clog2(MAX_ARGS + 1)
) (
    input  logic [7:0]            ch,
    input  msap_pkg::ctl_t        ctl_cur,
    input  logic [DEPTH_BITS-1:0] depth_cur,
    input  logic [CW-1:0]         cnt_cur,
    input  logic [7:0]            codes_cur [MAX_ARGS],
    output msap_pkg::ctl_t        ctl_next,
    output logic [DEPTH_BITS-1:0] depth_next,
    output logic [CW-1:0]         cnt_next,
    output logic [7:0]            codes_next [MAX_ARGS]
);
    import msap_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [CW-1:0]         CNT_MAX   = CW'(MAX_ARGS);

    logic                  do_start;
    logic                  do_body;
    logic                  do_choose;
    logic [DEPTH_BITS-1:0] depth_dec;
    kind_t                 k;

    always_comb
    begin
        ctl_next   = ctl_cur;
        depth_next = depth_cur;
        cnt_next   = cnt_cur;
        codes_next = codes_cur;
        do_start   = 1'b0;
        do_body    = 1'b0;
        do_choose  = 1'b0;
        k          = opener_kind(ch);
        depth_dec  = (depth_cur != '0) ? depth_cur - 1'b1 : '0;

        if (ch == CH_NUL) begin
            // A token of qualifiers only still counts, with code zero.
            do_choose = (ctl_cur.phase == PH_TOK);
        end else begin
            unique case (ctl_cur.phase)
                PH_RET:
                begin
                    ctl_next.ret_char = CH_NUL;
                    do_start          = 1'b1;
                end
                PH_TOK:
                begin
                    do_start = 1'b1;
                end
                PH_PTR:
                begin
                    do_body = 1'b1;
                end
                PH_AGG:
                begin
                    if (ch == kind_open(ctl_cur.open_kind)) begin
                        if (depth_cur == DEPTH_MAX) begin
                            ctl_next.halted = 1'b1;
                        end else begin
                            depth_next = depth_cur + 1'b1;
                        end
                    end else if (ch == kind_close(ctl_cur.open_kind)) begin
                        depth_next = depth_dec;
                        if (depth_dec == '0) begin
                            ctl_next.open_kind = KIND_NONE;
                            ctl_next.phase     = PH_TRAIL;
                        end
                    end
                end
                default:
                begin
                    ctl_next.after_at = 1'b0;
                    // Skip "@?" block marker, offset digits and, outside the receiver position, minus signs.
                    if (!(ctl_cur.after_at && ch == CH_QUEST) && !is_digit(ch) &&
                        !(ch == CH_MINUS && ctl_cur.arg_pos != POS_RECEIVER)) begin
                        do_start = 1'b1;
                    end
                end
            endcase
        end

        if (do_start) begin
            if (is_qual(ch)) begin
                ctl_next.phase = PH_TOK;
            end else begin
                do_choose = 1'b1;
                do_body   = 1'b1;
            end
        end

        if (do_choose) begin
            if (ctl_cur.arg_pos == POS_RETURN) begin
                ctl_next.ret_char = ch;
            end else if (ctl_cur.arg_pos == POS_EXPLICIT && !ctl_cur.halted) begin
                if (is_float(ch) || cnt_cur >= CNT_MAX) begin
                    ctl_next.halted = 1'b1;
                end else begin
                    for (int i = 0; i < MAX_ARGS; i++) begin
                        if (cnt_cur == CW'(i)) begin
                            codes_next[i] = ch;
                        end
                    end
                    cnt_next = cnt_cur + 1'b1;
                end
            end
            if (ctl_cur.arg_pos != POS_EXPLICIT) begin
                ctl_next.arg_pos = ctl_cur.arg_pos + 2'd1;
            end
        end

        if (do_body) begin
            priority if (ch == CH_CARET || is_qual(ch)) begin
                ctl_next.phase = PH_PTR;
            end else if (k != KIND_NONE) begin
                ctl_next.open_kind = k;
                depth_next         = DEPTH_BITS'(1);
                ctl_next.phase     = PH_AGG;
            end else if (ch == CH_AT) begin
                ctl_next.after_at = 1'b1;
                ctl_next.phase    = PH_TRAIL;
            end else begin
                ctl_next.phase = PH_TRAIL;
            end
        end
    end

endmodule

@@ rtl/method_signature_arg_parser_unit.sv @@
// Top level of the method signature argument parser: input beat register,
// parse state, result register. Depends on msap_pkg and msap_step.
//
// Usage
//   Input channel (in_valid / in_stall / sig_char) carries one byte of a
//   method type-encoding string per beat; a zero byte ends the string.
//   Output channel (out_valid / out_stall / result fields) carries one beat
//   per string, holding the return code, up to four explicit argument codes,
//   their count and the unsupported flag.
// Result path: a terminator passes from the input register into the result
//   register, which offers it on out_valid from then on.
// Throughput: one byte per cycle while in_stall is low; the parse step between
//   the input register and the state/result registers is combinational.
// Stall: a non-terminator byte never waits on the output side. A terminator
//   waits in the input register only while the result register is full and
//   out_stall is high; in_stall is raised for exactly that case.
// Reset: rst_n clears both beat registers and puts the parser at the start
//   of a return token, ready for a new string. The parser also returns to
//   that state after every terminator.
module method_signature_arg_parser_unit #(
    parameter int MAX_ARGS   = msap_pkg::MAX_ARGS_DEF,
    parameter int DEPTH_BITS = msap_pkg::DEPTH_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] sig_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] return_code,
    output logic [2:0] arg_count,
    output logic [7:0] arg_code_0,
    output logic [7:0] arg_code_1,
    output logic [7:0] arg_code_2,
    output logic [7:0] arg_code_3,
    output logic       unsupported
);
    import msap_pkg::*;

    localparam int CW = $clog2(MAX_ARGS + 1);

    // Input beat register.
    logic                  in_valid_reg;
    logic [7:0]            char_reg;

    // Parse state.
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [7:0]            codes_reg  [MAX_ARGS];
    logic [7:0]            codes_next [MAX_ARGS];

    // Result register.
    logic                  out_valid_reg;
    logic [7:0]            ret_reg;
    logic [2:0]            count_reg;
    logic [7:0]            arg_reg [4];
    logic                  unsup_reg;

    logic                  is_term;
    logic                  proc_go;
    logic [2:0]            count_sat;
    logic [7:0]            arg_sel [4];

    assign is_term  = (char_reg == CH_NUL);
    // Hold a terminator only while the result register cannot take it.
    assign in_stall = in_valid_reg && is_term && out_valid_reg && out_stall;
    assign proc_go  = in_valid_reg && !in_stall;

    msap_step #(
        .MAX_ARGS   (MAX_ARGS),
        .DEPTH_BITS (DEPTH_BITS),
        .CW         (CW)
    ) u_step (
        .ch         (char_reg),
        .ctl_cur    (ctl_reg),
        .depth_cur  (depth_reg),
        .cnt_cur    (cnt_reg),
        .codes_cur  (codes_reg),
        .ctl_next   (ctl_next),
        .depth_next (depth_next),
        .cnt_next   (cnt_next),
        .codes_next (codes_next)
    );

    // Saturate the count at the port's range.
    assign count_sat = (32'(cnt_next) > 32'd7) ? 3'd7 : 3'(cnt_next);

    // Report only collected codes; unused slots read as zero.
    for (genvar i = 0; i < 4; i++) begin : g_arg
        if (i < MAX_ARGS) begin : g_live
            assign arg_sel[i] = (32'(cnt_next) > i) ? codes_next[i] : CH_NUL;
        end else begin : g_absent
            assign arg_sel[i] = CH_NUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            char_reg <= sig_char;
        end
    end

    // Advance the parse state per byte; drop back to token start at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg   <= CTL_INIT;
            depth_reg <= '0;
            cnt_reg   <= '0;
        end else if (proc_go) begin
            if (is_term) begin
                ctl_reg   <= CTL_INIT;
                depth_reg <= '0;
                cnt_reg   <= '0;
            end else begin
                ctl_reg   <= ctl_next;
                depth_reg <= depth_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    // Code slots beyond the count are never reported, so they need no clear.
    always_ff @(posedge clk)
    begin
        if (proc_go && !is_term) begin
            codes_reg <= codes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (proc_go && is_term) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && is_term) begin
            ret_reg   <= ctl_next.ret_char;
            count_reg <= count_sat;
            arg_reg   <= arg_sel;
            unsup_reg <= ctl_next.halted;
        end
    end

    assign out_valid   = out_valid_reg;
    assign return_code = ret_reg;
    assign arg_count   = count_reg;
    assign arg_code_0  = arg_reg[0];
    assign arg_code_1  = arg_reg[1];
    assign arg_code_2  = arg_reg[2];
    assign arg_code_3  = arg_reg[3];
    assign unsupported = unsup_reg;

    // A terminator always leaves the parser at the start of a fresh string.
    a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && is_term) |=> (ctl_reg.phase == PH_RET && cnt_reg == '0 &&
                                  !ctl_reg.halted && ctl_reg.ret_char == CH_AT))
        else $error("parser state not restarted after terminator");

    // The input side waits only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled without output back-pressure");

    // Collected count never passes the argument limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cnt_reg) <= MAX_ARGS))
        else $error("argument count beyond limit");

    // A new result is loaded only after the previous one left or was absent.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(ret_reg) &&
                                          $stable(count_reg) && $stable(unsup_reg)))
        else $error("pending result overwritten");

endmodule

@@ test/sig_parse_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the method signature argument parser: watches both beat
// channels, predicts each result from the accepted bytes and compares it.
// Depends on msap_pkg for character codes, token positions and phase_t.
module sig_parse_checker #(
    parameter int MAX_ARGS   = msap_pkg::MAX_ARGS_DEF,
    parameter int DEPTH_BITS = msap_pkg::DEPTH_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] sig_char,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] return_code,
    input  logic [2:0] arg_count,
    input  logic [7:0] arg_code_0,
    input  logic [7:0] arg_code_1,
    input  logic [7:0] arg_code_2,
    input  logic [7:0] arg_code_3,
    input  logic       unsupported,
    output int         mismatch_count,
    output int         results_pending
);
    import msap_pkg::*;

    localparam int DEPTH_LIMIT = (1 << DEPTH_BITS) - 1;

    typedef struct packed {
        logic [7:0] ret;
        logic [2:0] count;
        logic [7:0] code0;
        logic [7:0] code1;
        logic [7:0] code2;
        logic [7:0] code3;
        logic       unsup;
    } sig_result_t;

    sig_result_t expected_results[$];
    int          errors;

    // parser state
    phase_t      cur_phase;
    logic [7:0]  agg_open;
    logic [7:0]  agg_close;
    int          agg_depth;
    logic        at_pending;
    logic [1:0]  tok_pos;
    int          n_args;
    logic [7:0]  kept_args [4];
    logic        halt;
    logic [7:0]  ret_seen;

    function automatic logic is_modifier(input logic [7:0] c);
        case (c)
            CH_Q_R_LOW, CH_Q_N_LOW, CH_Q_N_UP, CH_Q_O_LOW,
            CH_Q_O_UP, CH_Q_R_UP, CH_Q_V_UP: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_float_code(input logic [7:0] c);
        case (c)
            CH_F_LOW, CH_D_LOW, CH_D_UP: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function void clear_parse();
        cur_phase  = PH_RET;
        agg_open   = CH_NUL;
        agg_close  = CH_NUL;
        agg_depth  = 0;
        at_pending = 1'b0;
        tok_pos    = POS_RETURN;
        n_args     = 0;
        for (int i = 0; i < 4; i++) kept_args[i] = CH_NUL;
        halt       = 1'b0;
        ret_seen   = CH_AT;
    endfunction

    // Record the primary code of the token at the current position.
    function void take_code(input logic [7:0] c);
        if (tok_pos == POS_RETURN) begin
            ret_seen = c;
        end else if (tok_pos == POS_EXPLICIT && !halt) begin
            if (is_float_code(c) || n_args >= MAX_ARGS) begin
                halt = 1'b1;
            end else begin
                if (n_args < 4) kept_args[n_args] = c;
                n_args++;
            end
        end
        if (tok_pos != POS_EXPLICIT) tok_pos = tok_pos + 2'd1;
    endfunction

    function void enter_body(input logic [7:0] c);
        if (c == CH_CARET || is_modifier(c)) begin
            cur_phase = PH_PTR;
        end else if (c == CH_LBRACE || c == CH_LPAREN || c == CH_LBRACK) begin
            agg_open  = c;
            agg_close = (c == CH_LBRACE) ? CH_RBRACE :
                        (c == CH_LPAREN) ? CH_RPAREN : CH_RBRACK;
            agg_depth = 1;
            cur_phase = PH_AGG;
        end else begin
            at_pending = (c == CH_AT);
            cur_phase  = PH_TRAIL;
        end
    endfunction

    function void start_token(input logic [7:0] c);
        if (is_modifier(c)) begin
            cur_phase = PH_TOK;
        end else begin
            take_code(c);
            enter_body(c);
        end
    endfunction

    function void advance_parse(input logic [7:0] c);
        sig_result_t r;
        logic        skip;
        if (c == CH_NUL) begin
            if (cur_phase == PH_TOK) take_code(CH_NUL);
            r.ret   = ret_seen;
            r.count = (n_args > 7) ? 3'd7 : n_args[2:0];
            r.code0 = kept_args[0];
            r.code1 = kept_args[1];
            r.code2 = kept_args[2];
            r.code3 = kept_args[3];
            r.unsup = halt;
            expected_results.push_back(r);
            clear_parse();
        end else begin
            case (cur_phase)
                PH_RET: begin
                    ret_seen = CH_NUL;
                    start_token(c);
                end
                PH_TOK: start_token(c);
                PH_PTR: enter_body(c);
                PH_AGG: begin
                    if (c == agg_open) begin
                        if (agg_depth >= DEPTH_LIMIT) begin
                            agg_depth = DEPTH_LIMIT;
                            halt      = 1'b1;
                        end else begin
                            agg_depth++;
                        end
                    end else if (c == agg_close) begin
                        if (agg_depth > 0) agg_depth--;
                        if (agg_depth == 0) cur_phase = PH_TRAIL;
                    end
                end
                default: begin
                    skip = 1'b0;
                    if (at_pending) begin
                        at_pending = 1'b0;
                        skip = (c == CH_QUEST);
                    end
                    if (c >= CH_ZERO && c <= CH_NINE) skip = 1'b1;
                    if (c == CH_MINUS && tok_pos != POS_RECEIVER) skip = 1'b1;
                    if (!skip) start_token(c);
                end
            endcase
        end
    endfunction

    function void check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        sig_result_t want;
        if (!rst_n) begin
            clear_parse();
            expected_results.delete();
            errors = 0;
        end else begin
            // result side first: a result never belongs to a byte of this edge
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h %h %h %h %h %h %h",
                             $time, return_code, arg_count, arg_code_0, arg_code_1,
                             arg_code_2, arg_code_3, unsupported);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("return_code", want.ret, return_code);
                    check_field("arg_count", {5'd0, want.count}, {5'd0, arg_count});
                    check_field("arg_code_0", want.code0, arg_code_0);
                    check_field("arg_code_1", want.code1, arg_code_1);
                    check_field("arg_code_2", want.code2, arg_code_2);
                    check_field("arg_code_3", want.code3, arg_code_3);
                    check_field("unsupported", {7'd0, want.unsup}, {7'd0, unsupported});
                end
            end
            if (in_valid && !in_stall) advance_parse(sig_char);
        end
        results_pending <= expected_results.size();
        mismatch_count  <= errors;
    end

endmodule

@@ test/tb_method_signature_arg_parser_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for method_signature_arg_parser_unit: drives type-encoding
// strings byte by byte and gives the verdict. Depends on msap_pkg, the block
// and sig_parse_checker, which predicts and compares every result beat.
module tb_method_signature_arg_parser_unit;
    import msap_pkg::*;

    // Total bytes to send, directed strings included.
    localparam int TOTAL_BYTES  = 1700;
    // Longest legal quiet stretch is a sender gap or a run of receiver stalls;
    // allow a wide margin on top.
    localparam int IDLE_LIMIT   = 4000;

    localparam string SIMPLE_CODES = "cislqCISLQBv*#:?";
    localparam string ODD_CODES    = "bjAT!xZ";
    localparam string QUALIFIERS   = "rnNoORV";
    localparam string FLOAT_CODES  = "fdD";
    localparam string NAME_CHARS   = "ABSTxy_";

    typedef enum int {STALL_OFF, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] sig_char  = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] return_code;
    logic [2:0] arg_count;
    logic [7:0] arg_code_0;
    logic [7:0] arg_code_1;
    logic [7:0] arg_code_2;
    logic [7:0] arg_code_3;
    logic       unsupported;
    int         mismatch_count;
    int         results_pending;

    logic [7:0]  sig_buf[$];     // bytes of the string being built
    int          burst_left  = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    int          stall_cycle = 0;
    stall_mode_t stall_mode  = STALL_OFF;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    method_signature_arg_parser_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sig_char    (sig_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .return_code (return_code),
        .arg_count   (arg_count),
        .arg_code_0  (arg_code_0),
        .arg_code_1  (arg_code_1),
        .arg_code_2  (arg_code_2),
        .arg_code_3  (arg_code_3),
        .unsupported (unsupported)
    );

    sig_parse_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sig_char        (sig_char),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .return_code     (return_code),
        .arg_count       (arg_count),
        .arg_code_0      (arg_code_0),
        .arg_code_1      (arg_code_1),
        .arg_code_2      (arg_code_2),
        .arg_code_3      (arg_code_3),
        .unsupported     (unsupported),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Receiver: switch at random between stall patterns, including long
    // stretches with no stall at all.
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        stall_cycle++;
        case (stall_mode)
            STALL_OFF:   out_stall <= 1'b0;
            STALL_COIN:  out_stall <= ($urandom_range(0, 1) != 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
            default:     out_stall <= (stall_cycle % 5) < 2;
        endcase
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Drive one byte and hold it until accepted. Bursts of random length are
    // separated by random gaps; a gap of zero keeps valid high across bursts.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        sig_char <= c;
        // stall is settled by the falling edge; the beat moves at the next rise
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    // Send the buffered string followed by its terminator.
    task automatic send_sig();
        while (sig_buf.size() > 0) send_byte(sig_buf.pop_front());
        send_byte(CH_NUL);
    endtask

    function automatic void put(input string s);
        int i;
        for (i = 0; i < s.len(); i++) sig_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void put_digits(input int n);
        repeat (n) sig_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // Offsets trail each token; a minus only belongs after the receiver on.
    function automatic void add_offset(input bit allow_minus);
        if (allow_minus && $urandom_range(0, 7) == 0) sig_buf.push_back(CH_MINUS);
        put_digits($urandom_range(0, 3));
    endfunction

    function automatic void add_aggregate();
        logic [7:0] open_ch;
        logic [7:0] close_ch;
        case ($urandom_range(0, 2))
            0: begin open_ch = CH_LBRACE; close_ch = CH_RBRACE; end
            1: begin open_ch = CH_LPAREN; close_ch = CH_RPAREN; end
            default: begin open_ch = CH_LBRACK; close_ch = CH_RBRACK; end
        endcase
        sig_buf.push_back(open_ch);
        if (open_ch == CH_LBRACK) begin
            put_digits($urandom_range(1, 2));
        end else begin
            repeat ($urandom_range(0, 3)) sig_buf.push_back(pick(NAME_CHARS));
            sig_buf.push_back("=");
        end
        repeat ($urandom_range(0, 3)) sig_buf.push_back(pick(SIMPLE_CODES));
        // same-kind nesting, sometimes two deep
        if ($urandom_range(0, 3) == 0) begin
            sig_buf.push_back(open_ch);
            if ($urandom_range(0, 2) == 0) begin
                sig_buf.push_back(open_ch);
                sig_buf.push_back(pick(FLOAT_CODES));
                sig_buf.push_back(close_ch);
            end
            sig_buf.push_back(pick(SIMPLE_CODES));
            sig_buf.push_back(close_ch);
        end
        // brackets of another kind do not count toward the depth
        if ($urandom_range(0, 4) == 0) put("(U=ic)[2i]{x=}");
        sig_buf.push_back(close_ch);
    endfunction

    function automatic void add_token();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) sig_buf.push_back(pick(QUALIFIERS));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: sig_buf.push_back(pick(SIMPLE_CODES));
            4: begin
                sig_buf.push_back(CH_CARET);
                if ($urandom_range(0, 2) == 0) sig_buf.push_back(CH_CARET);
                if ($urandom_range(0, 3) == 0) sig_buf.push_back(pick(QUALIFIERS));
                if ($urandom_range(0, 2) == 0) add_aggregate();
                else sig_buf.push_back(pick(SIMPLE_CODES));
            end
            5, 6: add_aggregate();
            7: begin
                sig_buf.push_back(CH_AT);
                if ($urandom_range(0, 1) == 0) sig_buf.push_back(CH_QUEST);
            end
            8: sig_buf.push_back(pick(FLOAT_CODES));
            default: sig_buf.push_back(pick(ODD_CODES));
        endcase
    endfunction

    // Well-formed signature: return, receiver, selector, then explicit args.
    function automatic void build_signature();
        int n;
        add_token();
        add_offset(1'b0);
        if ($urandom_range(0, 7) == 0) add_token();
        else sig_buf.push_back(CH_AT);
        add_offset(1'b1);
        if ($urandom_range(0, 7) == 0) add_token();
        else put(":");
        add_offset(1'b1);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 4);
        repeat (n) begin
            add_token();
            add_offset(1'b1);
        end
    endfunction

    // Corrupt a well-formed signature: drop, replace or truncate bytes.
    function automatic void break_signature();
        int pos;
        repeat ($urandom_range(1, 3)) begin
            if (sig_buf.size() > 0) begin
                pos = $urandom_range(0, sig_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0: sig_buf.delete(pos);
                    1: sig_buf[pos] = 8'($urandom_range(1, 255));
                    default: while (sig_buf.size() > pos) void'(sig_buf.pop_back());
                endcase
            end
        end
    endfunction

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed strings ----
        send_sig();                               // empty: return code defaults to '@'
        put("v16@0:8");                 send_sig();
        put("i24@0:8i16q20");           send_sig();
        put("v@:iiii");                 send_sig();   // exactly four arguments
        put("v@:iiiii");                send_sig();   // one too many
        put("v@:if@");                  send_sig();   // float halts collection
        put("d@:dD");                   send_sig();   // float return is fine
        put("rnNoORVi@:ri");            send_sig();   // qualifiers skipped
        put("v@:r");                    send_sig();   // qualifier-only argument
        put("V");                       send_sig();   // qualifier-only return
        put("^{S=ii}16@0:8^i^^v^{T=^c}"); send_sig(); // pointers
        put("{S={T=i}i}@:{A={B=c}}(U=(V=i)c)[4[2i]]"); send_sig();
        put("v@:@?@@?");                send_sig();   // block counts as one token
        put("v@?:i");                   send_sig();   // block as receiver
        put("v-8@0:-4i-12");            send_sig();   // minus after return is a token
        put("v@:{S=i");                 send_sig();   // aggregate open at terminator
        put("v@:^");                    send_sig();   // pointer open at terminator
        put("v@:?:");
        sig_buf.push_back(8'h80);
        sig_buf.push_back(8'hFF);
        sig_buf.push_back(8'h7F);
        send_sig();
        // depth right at the limit, then closed again: no overflow
        put("v@:");
        repeat (255) sig_buf.push_back(CH_LBRACK);
        repeat (255) sig_buf.push_back(CH_RBRACK);
        put("i");
        send_sig();
        // more opens than the depth limit: depth saturates and flags unsupported
        put("c@:s");
        repeat (260) sig_buf.push_back(CH_LBRACE);
        put("}i");
        send_sig();

        // ---- random strings: mostly well-formed, some broken, some noise ----
        while (bytes_sent < TOTAL_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: build_signature();
                7: begin
                    build_signature();
                    break_signature();
                end
                8: repeat ($urandom_range(0, 20)) sig_buf.push_back(8'($urandom_range(0, 255)));
                default: if ($urandom_range(0, 1) == 0) sig_buf.push_back(pick(SIMPLE_CODES));
            endcase
            send_sig();
        end
        in_valid <= 1'b0;

        // drain: wait for every predicted result, then allow for the latency
        @(negedge clk);
        while (results_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
